FILE: rtl/core/tafps_pkg.sv
package tafps_pkg;

  localparam int TAPS      = 4;
  localparam int SAMPLE_W  = 12;
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PULSE_W   = 12;
  localparam int FRAC_BITS = 24;

  // shared multiplier operand and result widths
  localparam int A_W    = 34;
  localparam int B_W    = 25;
  localparam int PROD_W = 42;
  localparam int ACC_W  = 43;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd436208;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd2013266;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd1678;

  localparam logic AXIS_X = 1'b1;

  localparam int F_MIN      = -200;
  localparam int F_MAX_X    = 210;
  localparam int F_MAX_Y    = 230;
  localparam int SPAN_X     = F_MAX_X - F_MIN;
  localparam int SPAN_Y     = F_MAX_Y - F_MIN;
  localparam int PULSE_SPAN = 1200;
  localparam int PULSE_MIN  = 900;
  localparam int PULSE_MAX  = 2100;

  // floor(n/6) = (n * RECIP6) >> RECIP6_SH, exact for n < 2^19
  localparam int RECIP6_SH = 21;
  localparam int RECIP6    = ((1 << RECIP6_SH) + 5) / 6;

  // 1200 / 2^24 = 75 / 2^20
  localparam int SCALE_SH  = 20;
  localparam int SCALE_MUL = PULSE_SPAN / (1 << (FRAC_BITS - SCALE_SH));

  // floor(w/span) = (w * RECIP_SPAN) >> SPAN_SH, exact for w < 1200*span
  localparam int SPAN_SH      = 28;
  localparam int RECIP_SPAN_X = ((1 << SPAN_SH) + SPAN_X - 1) / SPAN_X;
  localparam int RECIP_SPAN_Y = ((1 << SPAN_SH) + SPAN_Y - 1) / SPAN_Y;

  localparam longint LIM_X    = longint'(SPAN_X) << FRAC_BITS;
  localparam longint LIM_Y    = longint'(SPAN_Y) << FRAC_BITS;
  localparam longint ACC_INIT = longint'(-F_MIN) << FRAC_BITS;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_NUM   = 14'b00000000000010,
    S_DIV6  = 14'b00000000000100,
    S_Y     = 14'b00000000001000,
    S_ERR   = 14'b00000000010000,
    S_DERIV = 14'b00000000100000,
    S_MP    = 14'b00000001000000,
    S_MD    = 14'b00000010000000,
    S_MI    = 14'b00000100000000,
    S_ACC   = 14'b00001000000000,
    S_RANGE = 14'b00010000000000,
    S_SCALE = 14'b00100000000000,
    S_REC   = 14'b01000000000000,
    S_PULSE = 14'b10000000000000
  } state_e;

  typedef struct packed {
    logic [A_W-1:0] op_a;
    logic [B_W-1:0] op_b;
    logic           acc_init;
    logic           acc_sub;
  } mac_ctrl_t;

endpackage

FILE: rtl/core/two_axis_filtered_pid_servo_top.sv
// One item in flight: a new item is accepted only after the previous result is
// loaded into the output register. Each item makes six passes through the single
// shared 34x25 multiplier (filter divide, three PID gains, pulse scaling, span divide).
// A result not yet taken from the output register holds the next item at the
// pulse scaling step.
// Reset (async, active low): history and setpoints cleared, default gains, output empty.
module two_axis_filtered_pid_servo_top import tafps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [GAIN_W-1:0]          cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       axis_i,
  input  logic [SAMPLE_W-1:0]        position_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       axis_out_o,
  output logic [PULSE_W-1:0]         pulse_width_us_o,
  output logic signed [DATA_W-1:0]   filtered_position_o
);

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [SAMPLE_W-1:0] setpoint_x_q, setpoint_y_q;
  logic [GAIN_W-1:0]   gain_p_q, gain_d_q, gain_i_q;

  logic [SAMPLE_W-1:0]      hist_q [2][TAPS];
  logic signed [DATA_W-1:0] yh_q   [2][2];
  logic signed [DATA_W-1:0] prev_err_q [2];
  logic signed [DATA_W-1:0] esum_q [2];

  logic                     axis_q;
  logic                     neg_q;
  logic [16:0]              num_abs_q;
  logic signed [DATA_W-1:0] y_q, e_q, de_q;
  logic                     lo_q, hi_q;

  logic                     out_valid_q;
  logic                     out_axis_q;
  logic [PULSE_W-1:0]       out_pulse_q;
  logic signed [DATA_W-1:0] out_y_q;

  mac_ctrl_t                mac_ctrl;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic                     accept;
  logic                     out_load;
  logic [15:0]              tap_sum;
  logic [17:0]              num;
  logic [14:0]              quot6;
  logic signed [DATA_W-1:0] y_new;
  logic [SAMPLE_W-1:0]      setpoint;
  logic [18:0]              scaled_w;
  logic [10:0]              pulse_ofs;
  logic [PULSE_W-1:0]       pulse;

  assign accept   = in_valid_i && in_ready_o;
  assign out_load = (state_q == S_PULSE) && (!out_valid_q || out_ready_i);

  assign in_ready_o = (state_q == S_IDLE);

  // filter numerator: x0 + 3x1 + 3x2 + x3 - 2*y[n-2]
  assign tap_sum = 16'(hist_q[axis_q][0]) + 16'(hist_q[axis_q][3])
                 + 16'(hist_q[axis_q][1]) * 16'd3 + 16'(hist_q[axis_q][2]) * 16'd3;
  assign num     = 18'(tap_sum) - (18'(yh_q[axis_q][1]) <<< 1);

  assign quot6     = prod[RECIP6_SH+14:RECIP6_SH];
  assign y_new     = neg_q ? -$signed({1'b0, quot6}) : $signed({1'b0, quot6});
  assign setpoint  = (axis_q == AXIS_X) ? setpoint_x_q : setpoint_y_q;
  assign scaled_w  = prod[SCALE_SH+18:SCALE_SH];
  assign pulse_ofs = prod[SPAN_SH+10:SPAN_SH];

  always_comb begin
    if (lo_q) begin
      pulse = PULSE_W'(PULSE_MIN);
    end else if (hi_q) begin
      pulse = PULSE_W'(PULSE_MAX);
    end else begin
      pulse = PULSE_W'(PULSE_MIN) + PULSE_W'(pulse_ofs);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mac_ctrl = '0;
    case (state_q)
      S_DIV6: begin
        mac_ctrl.op_a = A_W'(num_abs_q);
        mac_ctrl.op_b = B_W'(RECIP6);
      end
      S_MP: begin
        mac_ctrl.op_a = A_W'(e_q);
        mac_ctrl.op_b = B_W'(gain_p_q);
      end
      S_MD: begin
        mac_ctrl.op_a     = A_W'(de_q);
        mac_ctrl.op_b     = B_W'(gain_d_q);
        mac_ctrl.acc_init = 1'b1;
      end
      S_MI: begin
        mac_ctrl.op_a    = A_W'(esum_q[axis_q]);
        mac_ctrl.op_b    = B_W'(gain_i_q);
        mac_ctrl.acc_sub = 1'b1;
      end
      S_ACC: begin
        mac_ctrl.acc_sub = 1'b1;
      end
      S_SCALE: begin
        // only used when 0 < u < span*2^24, so u fits in 33 bits
        mac_ctrl.op_a = A_W'(acc[32:0]);
        mac_ctrl.op_b = B_W'(SCALE_MUL);
      end
      S_REC: begin
        mac_ctrl.op_a = A_W'(scaled_w);
        mac_ctrl.op_b = (axis_q == AXIS_X) ? B_W'(RECIP_SPAN_X) : B_W'(RECIP_SPAN_Y);
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  tafps_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .prod_o (prod),
    .acc_o  (acc)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_NUM;
      S_NUM:   state_d = S_DIV6;
      S_DIV6:  state_d = S_Y;
      S_Y:     state_d = S_ERR;
      S_ERR:   state_d = S_DERIV;
      S_DERIV: state_d = S_MP;
      S_MP:    state_d = S_MD;
      S_MD:    state_d = S_MI;
      S_MI:    state_d = S_ACC;
      S_ACC:   state_d = S_RANGE;
      S_RANGE: state_d = S_SCALE;
      // wait here while the output register is full: acc holds, so the
      // scaling product is recomputed unchanged every cycle
      S_SCALE: if (!out_valid_q || out_ready_i) state_d = S_REC;
      S_REC:   state_d = S_PULSE;
      S_PULSE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      setpoint_x_q <= '0;
      setpoint_y_q <= '0;
      gain_p_q     <= GAIN_P_RST;
      gain_d_q     <= GAIN_D_RST;
      gain_i_q     <= GAIN_I_RST;
      out_valid_q  <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < TAPS; k++) begin
          hist_q[a][k] <= '0;
        end
        yh_q[a][0]    <= '0;
        yh_q[a][1]    <= '0;
        prev_err_q[a] <= '0;
        esum_q[a]     <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SETPOINT_X: setpoint_x_q <= cfg_data_i[SAMPLE_W-1:0];
          REG_SETPOINT_Y: setpoint_y_q <= cfg_data_i[SAMPLE_W-1:0];
          REG_GAIN_P:     gain_p_q     <= cfg_data_i;
          REG_GAIN_D:     gain_d_q     <= cfg_data_i;
          REG_GAIN_I:     gain_i_q     <= cfg_data_i;
          default:        ;
        endcase
      end

      if (accept) begin
        for (int k = TAPS - 1; k > 0; k--) begin
          hist_q[axis_i][k] <= hist_q[axis_i][k-1];
        end
        hist_q[axis_i][0] <= position_sample_i;
      end

      if (state_q == S_Y) begin
        yh_q[axis_q][1] <= yh_q[axis_q][0];
        yh_q[axis_q][0] <= y_new;
      end

      if (state_q == S_DERIV) begin
        prev_err_q[axis_q] <= e_q;
        esum_q[axis_q]     <= sat16(17'(esum_q[axis_q]) + 17'(e_q));
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      axis_q <= axis_i;
    end
    if (state_q == S_NUM) begin
      neg_q     <= num[17];
      num_abs_q <= 17'(num[17] ? -num : num);
    end
    if (state_q == S_Y) begin
      y_q <= y_new;
    end
    if (state_q == S_ERR) begin
      e_q <= sat16(17'(y_q) - $signed({5'b0, setpoint}));
    end
    if (state_q == S_DERIV) begin
      de_q <= sat16(17'(e_q) - 17'(prev_err_q[axis_q]));
    end
    if (state_q == S_RANGE) begin
      lo_q <= acc[ACC_W-1] || (acc == '0);
      hi_q <= (axis_q == AXIS_X) ? (acc >= ACC_W'(LIM_X)) : (acc >= ACC_W'(LIM_Y));
    end
    if (out_load) begin
      out_axis_q  <= axis_q;
      out_pulse_q <= pulse;
      out_y_q     <= y_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign axis_out_o          = out_axis_q;
  assign pulse_width_us_o    = out_pulse_q;
  assign filtered_position_o = out_y_q;

endmodule

FILE: rtl/core/tafps_mac.sv
module tafps_mac import tafps_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  output logic signed [PROD_W-1:0] prod_o,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [A_W+B_W-1:0] full;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  assign full = $signed(ctrl_i.op_a) * $signed(ctrl_i.op_b);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_init) begin
      acc_d = ACC_W'(ACC_INIT) - ACC_W'(prod_q);
    end else if (ctrl_i.acc_sub) begin
      acc_d = acc_q - ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(full);
    acc_q  <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

FILE: rtl/core/tafps_checker.sv
module tafps_checker import tafps_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     axis_out_o,
  input logic [PULSE_W-1:0]       pulse_width_us_o,
  input logic signed [DATA_W-1:0] filtered_position_o
);

  // one item in flight: no second accept right after the first
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("in_ready high right after an accepted item");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pulse_width_us_o >= PULSE_W'(PULSE_MIN))
                 && (pulse_width_us_o <= PULSE_W'(PULSE_MAX)))
    else $error("pulse width outside 900..2100");

  // |y| <= 16383 for 12-bit samples
  a_filter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (filtered_position_o >= -16'sd16384)
                 && (filtered_position_o <= 16'sd16383))
    else $error("filtered position out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(axis_out_o) && $stable(pulse_width_us_o)
                                      && $stable(filtered_position_o)))
    else $error("result changed while stalled");

endmodule

bind two_axis_filtered_pid_servo_top tafps_checker u_tafps_checker (.*);
